// File: src/bbt_pkg.sv
// Shared types and constants for the bounds-table engine.
package bbt_pkg;

  localparam int ADDR_BITS  = 20;
  localparam int SLOT_LOG2  = 4;
  localparam int META_BYTES = 2;
  localparam int TAG_BITS   = 16;
  localparam int LG_BITS    = 5;
  localparam int IDX_BITS   = ADDR_BITS - SLOT_LOG2;

  typedef enum logic [1:0] {
    OP_REG    = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_CHECK,
    S_RANGE,
    S_FILL,
    S_EVAL,
    S_LBASE,
    S_TAG,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    logic [LG_BITS-1:0]  wdata;
    logic [IDX_BITS-1:0] raddr;
  } bnd_req_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    logic [TAG_BITS-1:0] wdata;
    logic [IDX_BITS-1:0] raddr;
  } tag_req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [ADDR_BITS-1:0] base;
    logic [LG_BITS-1:0]   lg;
    status_t              status;
  } result_t;

endpackage

// File: src/baggy_bounds_table_engine.sv
// Top level of the bounds-table engine: memories, sequencer, result register.
//
// Input channel: in_valid/in_stall carry one transaction of operation,
// address, request_size and tag_in (register, free, lookup; code 3 acts as
// lookup). Output channel: out_valid/out_stall carry one result transaction
// of tag_out, base_address, size_log2 and status for every input.
// One transaction is in flight at a time; in_stall stays high until its
// result has moved into the output register.
// From acceptance to out_valid the sequencer runs these states, paced by
// the single fill/clear port of the bounds memory and the one-step-per-cycle
// sizing loop: lookup S_EVAL, S_LBASE, S_TAG (a null address goes straight
// to S_DONE, an empty slot ends after S_EVAL); free S_EVAL, S_RANGE, then
// S_FILL over each slot of the object (an empty slot ends after S_EVAL);
// register S_SIZE, S_CHECK, S_RANGE, S_FILL (a null address goes straight
// to S_DONE, a size or alignment error ends after S_CHECK). in_stall falls
// as out_valid rises, so the next transaction can be taken while it is high.
// Reset: synchronous, active high. After reset the bounds memory is swept to
// zero, one entry per cycle, over all 65536 entries; in_stall is high meanwhile.
// When the receiver stalls, the result holds in the output register and the
// next transaction runs up to its result, then waits for the register.
module baggy_bounds_table_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [bbt_pkg::ADDR_BITS-1:0]     address,
  input  logic [bbt_pkg::ADDR_BITS-1:0]     request_size,
  input  logic [bbt_pkg::TAG_BITS-1:0]      tag_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bbt_pkg::TAG_BITS-1:0]      tag_out,
  output logic [bbt_pkg::ADDR_BITS-1:0]     base_address,
  output logic [bbt_pkg::LG_BITS-1:0]       size_log2,
  output logic [1:0]                        status
);

  bbt_pkg::bnd_req_t                 bnd_req;
  bbt_pkg::tag_req_t                 tag_req;
  bbt_pkg::result_t                  res;
  logic [bbt_pkg::LG_BITS-1:0]       bnd_rdata;
  logic [bbt_pkg::TAG_BITS-1:0]      tag_rdata;
  logic                              res_valid;
  logic                              res_take;
  logic                              load;

  assign res_take = !out_valid || !out_stall;
  assign load     = res_valid && res_take;

  bbt_bounds_ram u_bounds (
    .clk   (clk),
    .req   (bnd_req),
    .rdata (bnd_rdata)
  );

  bbt_tag_ram u_tags (
    .clk   (clk),
    .req   (tag_req),
    .rdata (tag_rdata)
  );

  bbt_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .address      (address),
    .request_size (request_size),
    .tag_in       (tag_in),
    .bnd_rdata    (bnd_rdata),
    .tag_rdata    (tag_rdata),
    .bnd_req      (bnd_req),
    .tag_req      (tag_req),
    .res          (res),
    .res_valid    (res_valid),
    .res_take     (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag_out      <= res.tag;
      base_address <= res.base;
      size_log2    <= res.lg;
      status       <= res.status;
    end
  end

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bbt_pkg::STAT_OK |->
      size_log2 >= bbt_pkg::LG_BITS'(bbt_pkg::SLOT_LOG2) &&
      size_log2 <= bbt_pkg::LG_BITS'(bbt_pkg::ADDR_BITS))
    else $error("ok result with size log2 out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bbt_pkg::STAT_OK |->
      tag_out == '0 && base_address == '0 && size_log2 == '0)
    else $error("failed result carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a transaction without going busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == bbt_pkg::STAT_OK || status == bbt_pkg::STAT_NULL ||
      status == bbt_pkg::STAT_BAD)
    else $error("result status code unused");

endmodule

// File: src/bbt_bounds_ram.sv
// Bounds table memory: one size-log2 entry per slot, registered read.
module bbt_bounds_ram (
  input  logic                           clk,
  input  bbt_pkg::bnd_req_t              req,
  output logic [bbt_pkg::LG_BITS-1:0]    rdata
);

  logic [bbt_pkg::LG_BITS-1:0] mem [2**bbt_pkg::IDX_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: src/bbt_tag_ram.sv
// Tag store memory: one tag per slot, kept for an object's last slot.
module bbt_tag_ram (
  input  logic                           clk,
  input  bbt_pkg::tag_req_t              req,
  output logic [bbt_pkg::TAG_BITS-1:0]   rdata
);

  logic [bbt_pkg::TAG_BITS-1:0] mem [2**bbt_pkg::IDX_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: src/bbt_seq.sv
// Sequencer and shared datapath: sizing, range sweep, lookup.
module bbt_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [bbt_pkg::ADDR_BITS-1:0]     address,
  input  logic [bbt_pkg::ADDR_BITS-1:0]     request_size,
  input  logic [bbt_pkg::TAG_BITS-1:0]      tag_in,
  input  logic [bbt_pkg::LG_BITS-1:0]       bnd_rdata,
  input  logic [bbt_pkg::TAG_BITS-1:0]      tag_rdata,
  output bbt_pkg::bnd_req_t                 bnd_req,
  output bbt_pkg::tag_req_t                 tag_req,
  output bbt_pkg::result_t                  res,
  output logic                              res_valid,
  input  logic                              res_take
);

  bbt_pkg::state_t                   state, state_next;
  logic [1:0]                        op, op_next;
  logic [bbt_pkg::ADDR_BITS-1:0]     addr, addr_next;
  logic [bbt_pkg::ADDR_BITS:0]       nm1, nm1_next;
  logic [bbt_pkg::TAG_BITS-1:0]      tag, tag_next;
  logic [bbt_pkg::LG_BITS-1:0]       lg, lg_next;
  logic [bbt_pkg::IDX_BITS-1:0]      ptr, ptr_next;
  logic [bbt_pkg::IDX_BITS-1:0]      last, last_next;
  logic [bbt_pkg::LG_BITS-1:0]       fill_val, fill_val_next;
  bbt_pkg::result_t                  res_next;

  logic [bbt_pkg::IDX_BITS-1:0]      idx;
  logic [bbt_pkg::LG_BITS-1:0]       sh;
  logic [bbt_pkg::IDX_BITS:0]        span_end;
  logic [bbt_pkg::IDX_BITS-1:0]      span_last;
  logic [bbt_pkg::ADDR_BITS-1:0]     hi_mask;
  logic [bbt_pkg::ADDR_BITS-1:0]     obj_top;
  logic                              accept;

  assign idx      = addr[bbt_pkg::ADDR_BITS-1:bbt_pkg::SLOT_LOG2];
  assign hi_mask  = {bbt_pkg::ADDR_BITS{1'b1}} << lg;
  assign obj_top  = addr | ~hi_mask;
  assign in_stall = (state != bbt_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign res_valid = (state == bbt_pkg::S_DONE);

  always_comb begin
    sh = lg - bbt_pkg::LG_BITS'(bbt_pkg::SLOT_LOG2);
    if (lg < bbt_pkg::LG_BITS'(bbt_pkg::SLOT_LOG2)) begin
      span_end = {1'b0, idx};
    end else if (sh >= bbt_pkg::LG_BITS'(bbt_pkg::IDX_BITS)) begin
      span_end = {(bbt_pkg::IDX_BITS+1){1'b1}};
    end else begin
      span_end = {1'b0, idx} + ((bbt_pkg::IDX_BITS+1)'(1) << sh)
                 - (bbt_pkg::IDX_BITS+1)'(1);
    end
    span_last = span_end[bbt_pkg::IDX_BITS] ? {bbt_pkg::IDX_BITS{1'b1}}
                                             : span_end[bbt_pkg::IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbt_pkg::S_CLEAR;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    addr     <= addr_next;
    nm1      <= nm1_next;
    tag      <= tag_next;
    lg       <= lg_next;
    last     <= last_next;
    fill_val <= fill_val_next;
    res      <= res_next;
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    addr_next     = addr;
    nm1_next      = nm1;
    tag_next      = tag;
    lg_next       = lg;
    ptr_next      = ptr;
    last_next     = last;
    fill_val_next = fill_val;
    res_next      = res;

    bnd_req.we    = 1'b0;
    bnd_req.waddr = ptr;
    bnd_req.wdata = fill_val;
    bnd_req.raddr = address[bbt_pkg::ADDR_BITS-1:bbt_pkg::SLOT_LOG2];
    tag_req.we    = 1'b0;
    tag_req.waddr = span_end[bbt_pkg::IDX_BITS-1:0];
    tag_req.wdata = tag;
    tag_req.raddr = obj_top[bbt_pkg::ADDR_BITS-1:bbt_pkg::SLOT_LOG2];

    unique case (state)
      bbt_pkg::S_CLEAR: begin
        bnd_req.we    = 1'b1;
        bnd_req.wdata = '0;
        ptr_next      = ptr + bbt_pkg::IDX_BITS'(1);
        if (ptr == {bbt_pkg::IDX_BITS{1'b1}}) begin
          state_next = bbt_pkg::S_IDLE;
        end
      end
      bbt_pkg::S_IDLE: begin
        if (accept) begin
          op_next   = operation;
          addr_next = address;
          tag_next  = tag_in;
          nm1_next  = {1'b0, request_size}
                      + (bbt_pkg::ADDR_BITS+1)'(bbt_pkg::META_BYTES - 1);
          lg_next   = bbt_pkg::LG_BITS'(bbt_pkg::SLOT_LOG2);
          res_next  = '{tag: '0, base: '0, lg: '0, status: bbt_pkg::STAT_NULL};
          if (operation == bbt_pkg::OP_REG) begin
            state_next = (address == '0) ? bbt_pkg::S_DONE : bbt_pkg::S_SIZE;
          end else if (operation == bbt_pkg::OP_FREE) begin
            state_next = bbt_pkg::S_EVAL;
          end else begin
            state_next = (address == '0) ? bbt_pkg::S_DONE : bbt_pkg::S_EVAL;
          end
        end
      end
      bbt_pkg::S_SIZE: begin
        if ((nm1 >> lg) != '0) begin
          lg_next = lg + bbt_pkg::LG_BITS'(1);
        end else begin
          state_next = bbt_pkg::S_CHECK;
        end
      end
      bbt_pkg::S_CHECK: begin
        if (lg > bbt_pkg::LG_BITS'(bbt_pkg::ADDR_BITS) || (addr & ~hi_mask) != '0) begin
          res_next.status = bbt_pkg::STAT_BAD;
          state_next      = bbt_pkg::S_DONE;
        end else begin
          fill_val_next = lg;
          state_next    = bbt_pkg::S_RANGE;
        end
      end
      bbt_pkg::S_RANGE: begin
        ptr_next   = idx;
        last_next  = span_last;
        tag_req.we = (op == bbt_pkg::OP_REG);
        state_next = bbt_pkg::S_FILL;
      end
      bbt_pkg::S_FILL: begin
        bnd_req.we = 1'b1;
        ptr_next   = ptr + bbt_pkg::IDX_BITS'(1);
        if (ptr == last) begin
          res_next   = '{tag: '0, base: addr, lg: lg, status: bbt_pkg::STAT_OK};
          state_next = bbt_pkg::S_DONE;
        end
      end
      bbt_pkg::S_EVAL: begin
        if (bnd_rdata == '0) begin
          state_next = bbt_pkg::S_DONE;
        end else if (op == bbt_pkg::OP_FREE) begin
          lg_next       = bnd_rdata;
          fill_val_next = '0;
          state_next    = bbt_pkg::S_RANGE;
        end else begin
          lg_next    = (bnd_rdata > bbt_pkg::LG_BITS'(bbt_pkg::ADDR_BITS))
                       ? bbt_pkg::LG_BITS'(bbt_pkg::ADDR_BITS) : bnd_rdata;
          state_next = bbt_pkg::S_LBASE;
        end
      end
      bbt_pkg::S_LBASE: begin
        res_next.base = addr & hi_mask;
        state_next    = bbt_pkg::S_TAG;
      end
      bbt_pkg::S_TAG: begin
        res_next   = '{tag: tag_rdata, base: res.base, lg: lg, status: bbt_pkg::STAT_OK};
        state_next = bbt_pkg::S_DONE;
      end
      bbt_pkg::S_DONE: begin
        if (res_take) begin
          state_next = bbt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bbt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sim/baggy_bounds_table_engine_checker.sv
// Checker for the bounds-table engine: tracks both channels, predicts each result, compares.
`timescale 1ns / 100ps

module baggy_bounds_table_engine_checker
  import bbt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [ADDR_BITS-1:0] request_size,
  input  logic [TAG_BITS-1:0]  tag_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [TAG_BITS-1:0]  tag_out,
  input  logic [ADDR_BITS-1:0] base_address,
  input  logic [LG_BITS-1:0]   size_log2,
  input  logic [1:0]           status,
  output int                   fail_count,
  output int                   pending
);

  localparam int          TABLE_DEPTH = 1 << IDX_BITS;
  localparam logic [63:0] ADDR_MASK   = (64'd1 << ADDR_BITS) - 64'd1;

  logic [LG_BITS-1:0]  bounds_mem [TABLE_DEPTH];
  logic [TAG_BITS-1:0] tag_mem    [TABLE_DEPTH];
  result_t             expected_results [$];

  task automatic apply_table_op(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr,
                                input logic [ADDR_BITS-1:0] req_size,
                                input logic [TAG_BITS-1:0] tag, output result_t res);
    logic [63:0] need;
    logic [63:0] alloc;
    logic [63:0] base;
    logic [63:0] last_slot;
    int unsigned lg;
    int unsigned span;
    int unsigned slot;
    res.tag    = '0;
    res.base   = '0;
    res.lg     = '0;
    res.status = STAT_OK;
    slot = int'(addr >> SLOT_LOG2);
    case (op)
      OP_REG: begin
        if (addr == '0) begin
          res.status = STAT_NULL;
        end else begin
          need = 64'(req_size) + 64'(META_BYTES);
          lg = SLOT_LOG2;
          while (lg < 62 && (64'd1 << lg) < need) lg++;
          alloc = 64'd1 << lg;
          if (lg > ADDR_BITS || (64'(addr) & (alloc - 64'd1)) != 64'd0) begin
            res.status = STAT_BAD;
          end else begin
            span = 1 << (lg - SLOT_LOG2);
            for (int unsigned i = 0; i < span && slot + i < TABLE_DEPTH; i++)
              bounds_mem[slot + i] = LG_BITS'(lg);
            tag_mem[(slot + span - 1) & (TABLE_DEPTH - 1)] = tag;
            res.base = addr;
            res.lg   = LG_BITS'(lg);
          end
        end
      end
      OP_FREE: begin
        lg = bounds_mem[slot];
        if (lg == 0) begin
          res.status = STAT_NULL;
        end else begin
          span = (lg >= SLOT_LOG2) ? (1 << (lg - SLOT_LOG2)) : 1;
          for (int unsigned i = 0; i < span && slot + i < TABLE_DEPTH; i++)
            bounds_mem[slot + i] = '0;
          res.base = addr;
          res.lg   = LG_BITS'(lg);
        end
      end
      default: begin
        lg = bounds_mem[slot];
        if (addr == '0 || lg == 0) begin
          res.status = STAT_NULL;
        end else begin
          if (lg > ADDR_BITS) lg = ADDR_BITS;
          alloc     = 64'd1 << lg;
          base      = 64'(addr) & ~(alloc - 64'd1) & ADDR_MASK;
          last_slot = ((base + alloc - 64'd1) & ADDR_MASK) >> SLOT_LOG2;
          res.tag   = tag_mem[int'(last_slot)];
          res.base  = ADDR_BITS'(base);
          res.lg    = LG_BITS'(lg);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    int      errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        bounds_mem[i] = '0;
        tag_mem[i]    = '0;
      end
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with none outstanding: base %0h status %0d",
                 base_address, status);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (tag_out !== want.tag) begin
            $error("tag_out mismatch: expected %0h, actual %0h", want.tag, tag_out);
            errs++;
          end
          if (base_address !== want.base) begin
            $error("base_address mismatch: expected %0h, actual %0h", want.base, base_address);
            errs++;
          end
          if (size_log2 !== want.lg) begin
            $error("size_log2 mismatch: expected %0d, actual %0d", want.lg, size_log2);
            errs++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_table_op(operation, address, request_size, tag_in, fresh);
        expected_results.push_back(fresh);
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end

endmodule

// File: sim/baggy_bounds_table_engine_tb.sv
// Testbench top for the bounds-table engine: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module baggy_bounds_table_engine_tb;
  import bbt_pkg::*;

  localparam logic [1:0] OP_ALT_LOOKUP  = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000000;
  localparam int         HOLD_CYCLES    = 300;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [1:0]           operation    = '0;
  logic [ADDR_BITS-1:0] address      = '0;
  logic [ADDR_BITS-1:0] request_size = '0;
  logic [TAG_BITS-1:0]  tag_in       = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [TAG_BITS-1:0]  tag_out;
  logic [ADDR_BITS-1:0] base_address;
  logic [LG_BITS-1:0]   size_log2;
  logic [1:0]           status;

  int fail_count;
  int pending;
  int snd_idle   = 9;
  int rcv_idle   = 82;
  int hold_left  = 0;
  int idle_cycles = 0;
  logic long_hold  = 1'b0;
  logic hold_taken = 1'b0;
  logic [ADDR_BITS-1:0] live_bases [$];

  baggy_bounds_table_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .address      (address),
    .request_size (request_size),
    .tag_in       (tag_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tag_out      (tag_out),
    .base_address (base_address),
    .size_log2    (size_log2),
    .status       (status)
  );

  baggy_bounds_table_engine_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .address      (address),
    .request_size (request_size),
    .tag_in       (tag_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tag_out      (tag_out),
    .base_address (base_address),
    .size_log2    (size_log2),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #4 clk = ~clk;

  // hold off for a long stretch once, otherwise stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic offer(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr,
                       input logic [ADDR_BITS-1:0] req, input logic [TAG_BITS-1:0] tag);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation    <= op;
    address      <= addr;
    request_size <= req;
    tag_in       <= tag;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int unsigned          pick;
    int unsigned          lg;
    int unsigned          k;
    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] sz;
    logic [1:0]           op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // well-formed register, mostly small objects
        lg = ($urandom_range(49) == 0) ? $urandom_range(16, 11) : $urandom_range(10, 4);
        if (lg == SLOT_LOG2) sz = ADDR_BITS'($urandom_range(14, 0));
        else sz = ADDR_BITS'($urandom_range((1 << lg) - 2, (1 << (lg - 1)) - 1));
        a = ADDR_BITS'($urandom()) & ~ADDR_BITS'((1 << lg) - 1);
        if (a == '0) a = ADDR_BITS'(1 << lg);
        offer(OP_REG, a, sz, TAG_BITS'($urandom()));
        live_bases.push_back(a);
        if (live_bases.size() > 64) void'(live_bases.pop_front());
      end else if (pick < 60) begin
        if (live_bases.size() != 0)
          a = live_bases[$urandom_range(live_bases.size() - 1)] + ADDR_BITS'($urandom_range(63));
        else
          a = ADDR_BITS'($urandom());
        op = ($urandom_range(9) == 0) ? OP_ALT_LOOKUP : OP_LOOKUP;
        offer(op, a, ADDR_BITS'($urandom()), TAG_BITS'($urandom()));
      end else if (pick < 75) begin
        if (live_bases.size() != 0) begin
          k = $urandom_range(live_bases.size() - 1);
          a = live_bases[k];
          live_bases.delete(k);
          if ($urandom_range(4) == 0) a = a + ADDR_BITS'($urandom_range(7, 1) << SLOT_LOG2);
        end else begin
          a = ADDR_BITS'($urandom());
        end
        offer(OP_FREE, a, ADDR_BITS'($urandom()), TAG_BITS'($urandom()));
      end else begin
        offer(2'($urandom_range(3)), ADDR_BITS'($urandom()), ADDR_BITS'($urandom()),
              TAG_BITS'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    offer(OP_LOOKUP, 20'h00000, 20'hFFFFF, 16'hFFFF);
    offer(OP_LOOKUP, 20'hFFFFF, 20'h00000, 16'h0000);
    offer(OP_FREE,   20'h00000, 20'h00000, 16'h0000);
    offer(OP_REG,    20'h00000, 20'h00005, 16'h1111);
    offer(OP_REG,    20'h00010, 20'h00000, 16'hFFFF);
    offer(OP_REG,    20'h00030, 20'h0000F, 16'h2222);
    offer(OP_REG,    20'h00040, 20'h0001E, 16'hA5C3);
    offer(OP_LOOKUP, 20'h0005F, 20'h00000, 16'h0000);
    offer(OP_REG,    20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    offer(OP_REG,    20'h80000, 20'hFFFFE, 16'h3333);
    offer(OP_REG,    20'h80000, 20'h7FFFE, 16'h1234);
    offer(OP_ALT_LOOKUP, 20'hFFFFF, 20'h00000, 16'h0000);
    // overlap, then free from inside the object
    offer(OP_REG,    20'h90000, 20'h00064, 16'h00FF);
    offer(OP_LOOKUP, 20'h90005, 20'h00000, 16'h0000);
    offer(OP_FREE,   20'h90040, 20'h00000, 16'h0000);
    offer(OP_LOOKUP, 20'h90080, 20'h00000, 16'h0000);
    offer(OP_LOOKUP, 20'h900C0, 20'h00000, 16'h0000);
    offer(OP_FREE,   20'h80000, 20'h00000, 16'h0000);
    // free that runs off the end of the table
    offer(OP_REG,    20'hFFFF0, 20'h0000E, 16'h0000);
    offer(OP_REG,    20'hFFF00, 20'h000C8, 16'h8001);
    offer(OP_FREE,   20'hFFFC0, 20'h00000, 16'h0000);
    offer(OP_LOOKUP, 20'hFFFF8, 20'h00000, 16'h0000);
    offer(OP_LOOKUP, 20'hFFF10, 20'h00000, 16'h0000);
    offer(OP_FREE,   20'h00010, 20'h00000, 16'h0000);
    offer(OP_FREE,   20'h00010, 20'h00000, 16'h0000);

    run_random(280);

    // drain before swapping the idle rates
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    snd_idle = 82;
    rcv_idle <= 9;
    run_random(280);

    snd_idle = 0;
    rcv_idle <= 0;
    long_hold <= 1'b1;
    run_random(290);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
